// ----- rtl/core/tmh_pkg.sv -----
// shared types, constants and helpers for the temporal median histogram core
// no dependencies; imported by every module of the block but tmh_ram
package tmh_pkg;

    localparam int ENTRIES     = 1024;
    localparam int COUNT_WIDTH = 16;
    localparam int BINS        = 256;
    localparam int BIN_W       = 8;
    localparam int ENTRY_W     = 10;
    localparam int SAMPLE_W    = 8;
    localparam int ENTRY_AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W      = ENTRY_AW + BIN_W;
    localparam int MEM_DEPTH   = 1 << ADDR_W;
    localparam int TOTAL_W     = COUNT_WIDTH + BIN_W;

    localparam logic OP_ACC   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_WR,
        S_SUM,
        S_SUM_END,
        S_SCAN,
        S_SCAN_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr_write;
        logic load;
        logic start_query;
        logic acc_write;
        logic issue;
        logic scan;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bin_last;
        logic out_busy;
    } dp_status_t;

    // row index of an entry in the count memory
    function automatic logic [ENTRY_AW-1:0] entry_idx(input logic [ENTRY_W-1:0] e);
        logic [31:0] w;
        w = 32'(e);
        return w[ENTRY_AW-1:0];
    endfunction

    function automatic logic entry_ok(input logic [ENTRY_W-1:0] e);
        return 32'(e) < 32'(ENTRIES);
    endfunction

endpackage

// ----- rtl/core/tmh_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tmh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tmh_ctrl.sv -----
// controller state machine: clearing pass, accumulate and query sequencing
// depends on tmh_pkg
module tmh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  tmh_pkg::dp_status_t status,
    output tmh_pkg::dp_cmd_t    cmd,
    output tmh_pkg::state_t     state
);
    import tmh_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (op == OP_ACC)
                    begin
                        state_next = S_ACC_WR;
                    end
                    else
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = S_SUM;
                    end
                end
            end
            S_ACC_WR:
            begin
                cmd.acc_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SUM:
            begin
                cmd.issue = 1'b1;
                if (status.bin_last)
                begin
                    state_next = S_SUM_END;
                end
            end
            S_SUM_END:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                cmd.scan  = 1'b1;
                if (status.bin_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                cmd.scan   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ----- rtl/core/tmh_dp.sv -----
// datapath: count memory, read-modify-write, two-pass median scan, output register
// depends on tmh_pkg and tmh_ram
module tmh_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tmh_pkg::ENTRY_W-1:0]      entry,
    input  logic [tmh_pkg::SAMPLE_W-1:0]     sample,
    input  tmh_pkg::dp_cmd_t                 cmd,
    output tmh_pkg::dp_status_t              status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tmh_pkg::ENTRY_W-1:0]      entry_out,
    output logic [tmh_pkg::SAMPLE_W-1:0]     median
);
    import tmh_pkg::*;

    logic [ADDR_W-1:0]      clr_addr_reg;
    logic                   rd_vld_reg;
    logic                   out_valid_reg;

    logic [ENTRY_W-1:0]     entry_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   ok_reg;
    logic [BIN_W-1:0]       bin_reg;
    logic [BIN_W-1:0]       rd_bin_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     run_reg;
    logic                   found_reg;
    logic [BIN_W-1:0]       median_reg;
    logic [ENTRY_W-1:0]     entry_out_reg;
    logic [SAMPLE_W-1:0]    median_out_reg;

    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr;
    logic [COUNT_WIDTH-1:0] rdata;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [TOTAL_W-1:0]     rd_ext;
    logic [TOTAL_W-1:0]     run_sum;

    // idle cycles read the bin of the incoming item for the accumulate
    assign raddr = cmd.issue ? {entry_idx(entry_reg), bin_reg}
                             : {entry_idx(entry), sample};

    assign count_inc = (rdata == {COUNT_WIDTH{1'b1}}) ? rdata : rdata + 1'b1;

    always_comb
    begin
        we    = 1'b0;
        waddr = {entry_idx(entry_reg), sample_reg};
        wdata = count_inc;
        if (cmd.clr_write)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else if (cmd.acc_write)
        begin
            we = ok_reg;
        end
    end

    tmh_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(MEM_DEPTH),
        .AW   (ADDR_W)
    ) u_counts (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_ext  = TOTAL_W'(rdata);
    assign run_sum = run_reg + rd_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            rd_vld_reg <= cmd.issue;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            entry_reg  <= entry;
            sample_reg <= sample;
            ok_reg     <= entry_ok(entry);
        end
        if (cmd.start_query)
        begin
            bin_reg    <= '0;
            total_reg  <= '0;
            run_reg    <= '0;
            found_reg  <= 1'b0;
            median_reg <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                bin_reg <= bin_reg + 1'b1;
            end
            if (rd_vld_reg || cmd.scan)
            begin
                if (rd_vld_reg && !cmd.scan)
                begin
                    total_reg <= total_reg + rd_ext;
                end
                else if (rd_vld_reg)
                begin
                    run_reg <= run_sum;
                    // first bin whose running total passes half the total
                    if (!found_reg && (run_sum > (total_reg >> 1)))
                    begin
                        found_reg  <= 1'b1;
                        median_reg <= rd_bin_reg;
                    end
                end
            end
        end
        rd_bin_reg <= bin_reg;
        if (cmd.out_load)
        begin
            entry_out_reg  <= entry_reg;
            median_out_reg <= ok_reg ? SAMPLE_W'(median_reg) : '0;
        end
    end

    assign status.clr_last = (clr_addr_reg == {ADDR_W{1'b1}});
    assign status.bin_last = (bin_reg == {BIN_W{1'b1}});
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign entry_out = entry_out_reg;
    assign median    = median_out_reg;

endmodule

// ----- rtl/core/temporal_median_histogram_core.sv -----
// temporal median histogram core: per-entry 256-bin count histograms with median query
// accumulate item: a read-modify-write on the single count memory; no new item is taken until its write
// query item: once accepted, the sum and scan passes run, then the result is loaded into the output register
// two 256-bin passes (sum, then scan) over one read port; a held result stalls the next query
// after reset the count memory is cleared one word a cycle, all 2^ADDR_W words (262144),
// with in_ready low; depends on tmh_pkg, tmh_ctrl, tmh_dp
module temporal_median_histogram_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [tmh_pkg::ENTRY_W-1:0]      entry,
    input  logic [tmh_pkg::SAMPLE_W-1:0]     sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tmh_pkg::ENTRY_W-1:0]      entry_out,
    output logic [tmh_pkg::SAMPLE_W-1:0]     median
);
    import tmh_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    state_t     state;

    tmh_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op      (op),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    tmh_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .entry    (entry),
        .sample   (sample),
        .cmd      (cmd),
        .status   (status),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .entry_out(entry_out),
        .median   (median)
    );

    // no result can appear during the clearing pass
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state == S_CLEAR) |-> !out_valid)
        else $error("result during clearing pass");

    // an accumulate never produces a result
    a_acc_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_ACC) |=> !$rose(out_valid))
        else $error("accumulate produced a result");

    // a result is only loaded at the end of a query scan
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state == S_DONE))
        else $error("result outside query completion");

    // a query always runs a full sum pass first
    a_query_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_QUERY) |=> (state == S_SUM))
        else $error("query did not start the sum pass");

endmodule
